FILE: sv/ftch_pkg.sv
// Package: payload types and register indexes for the flow-key CRC hash block.
`timescale 1ns / 1ps
`default_nettype none

package ftch_pkg;

  // Key length in bytes for each mode
  localparam int unsigned PairBytes  = 8;
  localparam int unsigned TupleBytes = 13;

  // Configuration register indexes
  localparam logic [2:0] REG_POLY_A     = 3'd0;
  localparam logic [2:0] REG_POLY_B     = 3'd1;
  localparam logic [2:0] REG_INIT_VALUE = 3'd2;
  localparam logic [2:0] REG_FINAL_XOR  = 3'd3;
  localparam logic [2:0] REG_REFLECT    = 3'd4;

  // Reset values (CRC-32 on A, CRC-32C on B)
  localparam logic [31:0] POLY_A_RST     = 32'h04C1_1DB7;
  localparam logic [31:0] POLY_B_RST     = 32'h1EDC_6F41;
  localparam logic [31:0] INIT_VALUE_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] FINAL_XOR_RST  = 32'hFFFF_FFFF;

  // Key modes
  localparam logic MODE_PAIR  = 1'b0;
  localparam logic MODE_TUPLE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } flow_key_t;

  typedef struct packed {
    logic [31:0] crc_a;
    logic [31:0] crc_b;
  } flow_hash_t;

endpackage

`default_nettype wire

FILE: sv/flow_tuple_crc32_hash.sv
// Top level: pipelined dual-polynomial CRC-32 hash of a flow key.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                         Transfer when
// -------  ----------------------------  --------------------------------
// input    in_valid, in_ready, in_data   in_valid && in_ready
// result   out_valid, out_ready, out_data out_valid && out_ready
// config   cfg_we, cfg_addr, cfg_wdata   cfg_we (no wait, no read-back)
//
// Stages 0..12 fold one key byte each (8 shift/xor steps) into both CRCs
// (8..12 pass through for pair keys); the output stage applies reflection and xor.
// One key is taken every cycle while the result side keeps up.
// Reset (synchronous, rst_n low) clears all stage valid bits and loads the
// CRC-32 / CRC-32C defaults into the configuration registers.
// When the result register holds a transfer that is not taken, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated.

module flow_tuple_crc32_hash
  import ftch_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire flow_key_t   in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output flow_hash_t       out_data,
  // configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  localparam int unsigned KeyBits = 8 * TupleBytes;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [31:0] poly_a_r, poly_b_r, init_value_r, final_xor_r;
  logic        reflect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_a_r     <= POLY_A_RST;
      poly_b_r     <= POLY_B_RST;
      init_value_r <= INIT_VALUE_RST;
      final_xor_r  <= FINAL_XOR_RST;
      reflect_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POLY_A:     poly_a_r     <= cfg_wdata;
        REG_POLY_B:     poly_b_r     <= cfg_wdata;
        REG_INIT_VALUE: init_value_r <= cfg_wdata;
        REG_FINAL_XOR:  final_xor_r  <= cfg_wdata;
        REG_REFLECT:    reflect_r    <= cfg_wdata[0];
        default: ; // indexes past the register list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------
  // CRC helpers
  // ---------------------------------------------------------------
  // One byte folded in, MSB-first (LSB-first when refl is set): eight shift/xor steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data,
                                           input logic [31:0] poly, input logic refl);
    logic [7:0]  b;
    logic [31:0] c;
    for (int i = 0; i < 8; i++) b[i] = refl ? data[7-i] : data[i];
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) c = {c[30:0], 1'b0} ^ (c[31] ? poly : 32'h0);
    return c;
  endfunction

  function automatic logic [31:0] crc_final(input logic [31:0] crc, input logic refl,
                                            input logic [31:0] xo);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = refl ? crc[31-i] : crc[i];
    return r ^ xo;
  endfunction

  // ---------------------------------------------------------------
  // Byte pipeline: stage s holds the CRCs after key byte s
  // ---------------------------------------------------------------
  logic                advance;
  logic                stg_valid_r   [TupleBytes];
  // mode and key are only needed up to the stage before the last byte
  logic                stg_mode_r    [TupleBytes-1];
  logic [KeyBits-1:0]  stg_key_r     [TupleBytes-1];
  logic [31:0]         stg_crc_a_r   [TupleBytes];
  logic [31:0]         stg_crc_b_r   [TupleBytes];
  logic [31:0]         stg_crc_a_nxt [TupleBytes];
  logic [31:0]         stg_crc_b_nxt [TupleBytes];

  logic [KeyBits-1:0]  in_key;

  // Whole pipeline moves unless the result register is blocked
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  assign in_key = {in_data.src_addr, in_data.dst_addr,
                   in_data.sport, in_data.dport, in_data.proto};

  always_comb begin
    // Stage 0 takes the first byte straight from the input
    stg_crc_a_nxt[0] = crc_byte(init_value_r, in_key[KeyBits-1 -: 8], poly_a_r, reflect_r);
    stg_crc_b_nxt[0] = crc_byte(init_value_r, in_key[KeyBits-1 -: 8], poly_b_r, reflect_r);
    for (int s = 1; s < TupleBytes; s++) begin
      // Bytes past the address pair only count in five-tuple mode
      if ((s < int'(PairBytes)) || (stg_mode_r[s-1] == MODE_TUPLE)) begin
        stg_crc_a_nxt[s] = crc_byte(stg_crc_a_r[s-1], stg_key_r[s-1][KeyBits-1-8*s -: 8],
                                    poly_a_r, reflect_r);
        stg_crc_b_nxt[s] = crc_byte(stg_crc_b_r[s-1], stg_key_r[s-1][KeyBits-1-8*s -: 8],
                                    poly_b_r, reflect_r);
      end else begin
        stg_crc_a_nxt[s] = stg_crc_a_r[s-1];
        stg_crc_b_nxt[s] = stg_crc_b_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < TupleBytes; s++) stg_valid_r[s] <= 1'b0;
    end else if (advance) begin
      stg_valid_r[0] <= in_valid;
      for (int s = 1; s < TupleBytes; s++) stg_valid_r[s] <= stg_valid_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_mode_r[0] <= in_data.mode;
      stg_key_r[0]  <= in_key;
      for (int s = 1; s < TupleBytes-1; s++) begin
        stg_mode_r[s] <= stg_mode_r[s-1];
        stg_key_r[s]  <= stg_key_r[s-1];
      end
      for (int s = 0; s < TupleBytes; s++) begin
        stg_crc_a_r[s] <= stg_crc_a_nxt[s];
        stg_crc_b_r[s] <= stg_crc_b_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------
  // Output stage: reflect and final xor, held until transferred
  // ---------------------------------------------------------------
  logic       out_valid_r;
  flow_hash_t out_data_r, out_data_nxt;

  assign out_data_nxt = {crc_final(stg_crc_a_r[TupleBytes-1], reflect_r, final_xor_r),
                         crc_final(stg_crc_b_r[TupleBytes-1], reflect_r, final_xor_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stg_valid_r[TupleBytes-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: test/flow_hash_checker.sv
// Checker: predicts both CRCs of each accepted flow key and compares the hash transfers.
`timescale 1ns / 1ps

module flow_hash_checker
  import ftch_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire flow_key_t   in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire flow_hash_t  out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  output int unsigned      hashes_pending,
  output int unsigned      fail_count
);

  // shadow of the block's CRC settings
  logic [31:0] poly_a_q;
  logic [31:0] poly_b_q;
  logic [31:0] init_q;
  logic [31:0] xor_q;
  logic        reflect_q;

  flow_hash_t  hashes_due[$];
  int unsigned n_fail = 0;

  initial begin
    hashes_pending = 0;
    fail_count     = 0;
  end

  // CRC of one key: bytes enter the top of the register, shifted MSB-first (LSB-first when reflect_q is set)
  function automatic logic [31:0] key_crc(input flow_key_t key, input logic [31:0] poly);
    logic [103:0] stream;
    int unsigned  n_bytes;
    int unsigned  k;
    int unsigned  i;
    logic [31:0]  crc;
    logic [31:0]  mirrored;
    logic [7:0]   octet;
    logic [7:0]   flipped;
    stream  = {key.src_addr, key.dst_addr, key.sport, key.dport, key.proto};
    n_bytes = (key.mode == MODE_TUPLE) ? TupleBytes : PairBytes;
    crc     = init_q;
    for (k = 0; k < n_bytes; k++) begin
      octet = stream[103 - 8*k -: 8];
      if (reflect_q) begin
        for (i = 0; i < 8; i++) flipped[i] = octet[7 - i];
        octet = flipped;
      end
      crc ^= {octet, 24'h0};
      for (i = 0; i < 8; i++) crc = crc[31] ? ((crc << 1) ^ poly) : (crc << 1);
    end
    if (reflect_q) begin
      for (i = 0; i < 32; i++) mirrored[i] = crc[31 - i];
      crc = mirrored;
    end
    return crc ^ xor_q;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch: got %08h, expected %08h", $time, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk) begin : watch
    flow_hash_t want;
    if (!rst_n) begin
      poly_a_q  = POLY_A_RST;
      poly_b_q  = POLY_B_RST;
      init_q    = INIT_VALUE_RST;
      xor_q     = FINAL_XOR_RST;
      reflect_q = 1'b1;
      hashes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_POLY_A:     poly_a_q  = cfg_wdata;
          REG_POLY_B:     poly_b_q  = cfg_wdata;
          REG_INIT_VALUE: init_q    = cfg_wdata;
          REG_FINAL_XOR:  xor_q     = cfg_wdata;
          REG_REFLECT:    reflect_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want.crc_a = key_crc(in_data, poly_a_q);
        want.crc_b = key_crc(in_data, poly_b_q);
        hashes_due.insert(hashes_due.size(), want);
      end
      if (out_valid && out_ready) begin
        if (hashes_due.size() == 0) begin
          report_mismatch("hash with nothing pending", out_data.crc_a, '0);
        end else begin
          want = hashes_due.pop_front();
          if (out_data.crc_a !== want.crc_a) report_mismatch("crc_a", out_data.crc_a, want.crc_a);
          if (out_data.crc_b !== want.crc_b) report_mismatch("crc_b", out_data.crc_b, want.crc_b);
        end
      end
    end
    hashes_pending <= hashes_due.size();
    fail_count     <= n_fail;
  end

endmodule

FILE: test/testbench.sv
// Testbench top: drives flow keys and CRC settings into the hash block and gives the verdict.
`timescale 1ns / 1ps

module testbench;
  import ftch_pkg::*;

  // Receiver hold-off long enough to back the 14-stage pipe up to the input.
  localparam int unsigned HOLD_CYCLES      = 300;
  // Cycles with no transfer on either channel before the run is called hung.
  localparam int unsigned QUIET_LIMIT      = 4000;
  // Idle cycles after the last hash, to catch stray transfers.
  localparam int unsigned TAIL_CYCLES      = 30;
  localparam int unsigned KEYS_PER_PHASE   = 88;
  // First index past the register file; writes there must be dropped.
  localparam logic [2:0]  REG_SPARE        = REG_REFLECT + 3'd1;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  flow_key_t   in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = REG_POLY_A;
  logic [31:0] cfg_wdata = '0;

  logic        in_ready;
  logic        out_valid;
  flow_hash_t  out_data;
  int unsigned hashes_pending;
  int unsigned fail_count;

  // Idle rates in percent; the sender's is used by the stimulus process,
  // the receiver's is handed over with nonblocking writes.
  int unsigned tx_idle_pct  = 32;
  int unsigned rx_idle_pct  = 78;
  // Bumped to ask the receiver for one long hold-off.
  int unsigned hold_ticket  = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  flow_tuple_crc32_hash u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  flow_hash_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .hashes_pending (hashes_pending),
    .fail_count     (fail_count)
  );

  // Watchdog: any transfer on either channel resets the quiet count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAIL flow_tuple_crc32_hash");
        $finish;
      end
    end
  end

  // Receiver: random ready at the current idle rate, plus a long hold-off
  // whenever a new ticket shows up. Sender keeps offering meanwhile, so the
  // pipe fills and in_ready has to drop.
  initial begin : receiver
    int unsigned hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic flow_key_t make_key(input logic mode, input logic [31:0] sa,
                                         input logic [31:0] da, input logic [15:0] sp,
                                         input logic [15:0] dp, input logic [7:0] pr);
    flow_key_t key;
    key.mode     = mode;
    key.src_addr = sa;
    key.dst_addr = da;
    key.sport    = sp;
    key.dport    = dp;
    key.proto    = pr;
    return key;
  endfunction

  // Mostly random words, with all-zero and all-one values mixed in often.
  function automatic logic [31:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom();
  endfunction

  function automatic flow_key_t random_key();
    return make_key($urandom_range(1) ? MODE_TUPLE : MODE_PAIR, pick_word(), pick_word(),
                    16'(pick_word()), 16'(pick_word()), 8'(pick_word()));
  endfunction

  // One transfer on the input channel; returns at the accepting edge with
  // in_valid still high, so the caller either sends again or lowers it.
  task automatic send_key(input flow_key_t key);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lower valid and wait until every predicted hash has come out. The first
  // edge is needed since the pending count is a registered copy of the checker's queue size.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (hashes_pending != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Corner keys: field extremes, ignored port/proto bytes in pair mode,
  // single set bits at either end of every field, and a plain TCP tuple.
  task automatic send_directed();
    send_key(make_key(MODE_PAIR,  '0, '0, '0, '0, '0));
    send_key(make_key(MODE_PAIR,  '1, '1, '1, '1, '1));
    send_key(make_key(MODE_PAIR,  '0, '0, '1, '1, '1));
    send_key(make_key(MODE_PAIR,  $urandom(), $urandom(), 16'($urandom()),
                      16'($urandom()), 8'($urandom())));
    send_key(make_key(MODE_TUPLE, '0, '0, '0, '0, '0));
    send_key(make_key(MODE_TUPLE, '1, '1, '1, '1, '1));
    send_key(make_key(MODE_TUPLE, 32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001, 8'h80));
    send_key(make_key(MODE_TUPLE, 32'h0000_0001, 32'h8000_0000, 16'h0001, 16'h8000, 8'h01));
    send_key(make_key(MODE_TUPLE, 32'hC0A8_0001, 32'h0A00_0001, 16'd443, 16'd51000, 8'd6));
    send_key(random_key());
  endtask

  // One settings phase: wait for the pipe to empty, program all five
  // registers (reflect with junk in its upper bits), poke an unused index,
  // then stream keys at the given idle rates.
  task automatic run_phase(input logic [31:0] pa, input logic [31:0] pb,
                           input logic [31:0] init_v, input logic [31:0] fx,
                           input logic refl, input int unsigned tx_pct,
                           input int unsigned rx_pct, input bit hold,
                           input bit directed, input int unsigned n_keys);
    drain();
    write_reg(REG_POLY_A, pa);
    write_reg(REG_POLY_B, pb);
    write_reg(REG_INIT_VALUE, init_v);
    write_reg(REG_FINAL_XOR, fx);
    write_reg(REG_REFLECT, ($urandom() & 32'hFFFF_FFFE) | 32'(refl));
    write_reg(REG_SPARE + 3'($urandom_range(2)), $urandom());
    cfg_we      <= 1'b0;
    tx_idle_pct  = tx_pct;
    rx_idle_pct <= rx_pct;
    if (hold) hold_ticket <= hold_ticket + 1;
    if (directed) send_directed();
    repeat (n_keys) send_key(random_key());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender sparse-ish, receiver mostly stalled.
    // Reset defaults (CRC-32 / CRC-32C) with no register written yet.
    send_directed();
    // Degenerate settings: zero and all-ones polynomials, no init, no xor, no reflect.
    run_phase('0, '1, '0, '0, 1'b0, 32, 78, 1'b0, 1'b1, 0);
    run_phase(POLY_A_RST, POLY_B_RST, INIT_VALUE_RST, FINAL_XOR_RST, 1'b1,
              32, 78, 1'b0, 1'b0, KEYS_PER_PHASE);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom()),
              32, 78, 1'b0, 1'b0, KEYS_PER_PHASE);
    // Roles swapped.
    run_phase('1, '0, '1, '1, 1'b1, 78, 32, 1'b0, 1'b0, KEYS_PER_PHASE);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom()),
              78, 32, 1'b0, 1'b0, KEYS_PER_PHASE);
    // Full rate, first with a long receiver hold-off to back up the pipe.
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 1'b0,
              0, 0, 1'b1, 1'b0, KEYS_PER_PHASE);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 1'b1,
              0, 0, 1'b0, 1'b0, KEYS_PER_PHASE);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS flow_tuple_crc32_hash");
    end else begin
      $display("FAIL flow_tuple_crc32_hash");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ftch_pkg.sv
sv/flow_tuple_crc32_hash.sv
test/flow_hash_checker.sv
test/testbench.sv
